// File: hdl/sfcs_pkg.sv
// Shared types, opcodes and command microcode table for the SPI flash sequencer.
// No dependencies.
`default_nettype none
package sfcs_pkg;

  localparam int PAGE_BYTES = 256;
  localparam int FILL_W     = $clog2(PAGE_BYTES + 1);
  localparam int BUF_AW     = 8;
  localparam logic [5:0] SEQ_IDLE = 6'd63;
  localparam logic [5:0] SEQ_LEN  = 6'd16;

  localparam logic [3:0] OP_TICK      = 4'd0;
  localparam logic [3:0] OP_LOAD      = 4'd1;
  localparam logic [3:0] OP_STATUS    = 4'd2;
  localparam logic [3:0] OP_ID        = 4'd3;
  localparam logic [3:0] OP_ERASE4K   = 4'd4;
  localparam logic [3:0] OP_ERASE32K  = 4'd5;
  localparam logic [3:0] OP_ERASE64K  = 4'd6;
  localparam logic [3:0] OP_PROGRAM   = 4'd7;
  localparam logic [3:0] OP_RESET     = 4'd8;
  localparam logic [3:0] OP_SLEEP     = 4'd9;
  localparam logic [3:0] OP_WAKE      = 4'd10;

  localparam logic [4:0] RX_LEN = 5'd17;
  localparam logic [4:0] TX_LEN = 5'd24;

  typedef enum logic [3:0] {
    K_FIN   = 4'd0,
    K_BEGIN = 4'd1,
    K_END   = 4'd2,
    K_TX    = 4'd3,
    K_A2    = 4'd4,
    K_A1    = 4'd5,
    K_A0    = 4'd6,
    K_DATA  = 4'd7,
    K_FF8   = 4'd8,
    K_RX    = 4'd9,
    K_RXD   = 4'd10
  } kind_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] val;
  } elem_t;

  typedef struct packed {
    logic [3:0]  opcode;
    logic [23:0] flash_address;
    logic [7:0]  data_byte;
    logic        miso_bit;
  } in_item_t;

  typedef struct packed {
    logic        cs_n;
    logic        sclk;
    logic        mosi;
    logic        miso_enable;
    logic        busy_res;
    logic [31:0] read_value;
    logic        read_done;
    logic        rejected;
  } out_item_t;

  // item after front-end decode
  typedef struct packed {
    in_item_t item;
    logic     is_load;
    logic     is_cmd;
  } cls_item_t;

  function automatic elem_t mk(input kind_t k, input logic [7:0] v);
    elem_t e;
    e.kind = k;
    e.val  = v;
    return e;
  endfunction

  function automatic elem_t tx(input logic [7:0] v);
    return mk(K_TX, v);
  endfunction

  // Erase and program share the write-enable frame and address bytes.
  function automatic elem_t wr_elem(input logic [5:0] step, input logic [7:0] opc,
                                    input logic data);
    elem_t e;
    e = mk(K_FIN, 8'h00);
    case (step)
      6'd0: e = mk(K_BEGIN, 8'h00);
      6'd1: e = tx(8'h06);
      6'd2: e = mk(K_END, 8'h00);
      6'd3: e = mk(K_BEGIN, 8'h00);
      6'd4: e = tx(opc);
      6'd5: e = mk(K_A2, 8'h00);
      6'd6: e = mk(K_A1, 8'h00);
      6'd7: e = mk(K_A0, 8'h00);
      6'd8: e = data ? mk(K_DATA, 8'h00) : mk(K_END, 8'h00);
      6'd9: e = data ? mk(K_END, 8'h00) : mk(K_FIN, 8'h00);
      default: e = mk(K_FIN, 8'h00);
    endcase
    return e;
  endfunction

  function automatic elem_t prog_elem(input logic [3:0] cmd, input logic [5:0] step);
    elem_t e;
    e = mk(K_FIN, 8'h00);
    unique case (cmd)
      OP_STATUS: begin
        case (step)
          6'd0: e = mk(K_BEGIN, 8'h00);
          6'd1: e = tx(8'h05);
          6'd2: e = mk(K_RX, 8'h00);
          6'd3: e = mk(K_END, 8'h00);
          default: e = mk(K_FIN, 8'h00);
        endcase
      end
      OP_ID: begin
        case (step)
          6'd0:  e = mk(K_BEGIN, 8'h00);
          6'd1:  e = tx(8'h90);
          6'd2:  e = tx(8'h00);
          6'd3:  e = tx(8'h00);
          6'd4:  e = tx(8'h00);
          6'd5:  e = mk(K_RX, 8'h00);
          6'd6:  e = mk(K_RX, 8'h00);
          6'd7:  e = mk(K_END, 8'h00);
          6'd8:  e = mk(K_BEGIN, 8'h00);
          6'd9:  e = tx(8'h9F);
          6'd10: e = mk(K_RXD, 8'h00);
          6'd11: e = mk(K_RX, 8'h00);
          6'd12: e = mk(K_RX, 8'h00);
          6'd13: e = mk(K_END, 8'h00);
          default: e = mk(K_FIN, 8'h00);
        endcase
      end
      OP_ERASE4K:  e = wr_elem(step, 8'h20, 1'b0);
      OP_ERASE32K: e = wr_elem(step, 8'h52, 1'b0);
      OP_ERASE64K: e = wr_elem(step, 8'hD8, 1'b0);
      OP_PROGRAM:  e = wr_elem(step, 8'h02, 1'b1);
      OP_RESET: begin
        case (step)
          6'd0: e = mk(K_BEGIN, 8'h00);
          6'd1: e = mk(K_FF8, 8'h00);
          6'd2: e = mk(K_END, 8'h00);
          6'd3: e = mk(K_BEGIN, 8'h00);
          6'd4: e = tx(8'hAB);
          6'd5: e = mk(K_END, 8'h00);
          default: e = mk(K_FIN, 8'h00);
        endcase
      end
      OP_SLEEP, OP_WAKE: begin
        case (step)
          6'd0: e = mk(K_BEGIN, 8'h00);
          6'd1: e = tx((cmd == OP_SLEEP) ? 8'hB9 : 8'hAB);
          6'd2: e = mk(K_END, 8'h00);
          default: e = mk(K_FIN, 8'h00);
        endcase
      end
      default: e = mk(K_FIN, 8'h00);
    endcase
    return e;
  endfunction

endpackage
`default_nettype wire

// File: hdl/sfcs_front.sv
// Front end: takes input beats, decodes the opcode class, and holds them in a
// two-entry queue for the back end. Depends on sfcs_pkg.
`default_nettype none
module sfcs_front (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              push,
  output logic                   full,
  input  wire sfcs_pkg::in_item_t item,
  output logic                   q_valid,
  output sfcs_pkg::cls_item_t    q_item,
  input  wire logic              q_pop
);
  import sfcs_pkg::*;

  cls_item_t  slot [2];
  logic       rd_ptr;
  logic       wr_ptr;
  logic [1:0] count;
  logic       do_push;
  cls_item_t  cls;

  always_comb begin
    cls.item    = item;
    cls.is_load = (item.opcode == OP_LOAD);
    cls.is_cmd  = (item.opcode >= OP_STATUS) && (item.opcode <= OP_WAKE);
  end

  assign full    = (count == 2'd2);
  assign do_push = push && !full;
  assign q_valid = (count != 2'd0);
  assign q_item  = slot[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot[wr_ptr] <= cls;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= 1'b0;
      wr_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) wr_ptr <= !wr_ptr;
      if (q_pop && q_valid) rd_ptr <= !rd_ptr;
      count <= count + 2'(do_push) - 2'(q_pop && q_valid);
    end
  end

endmodule
`default_nettype wire

// File: hdl/sfcs_back.sv
// Back end: command sequencer that turns each queued beat into one result beat with one pin write,
// with the page buffer memory and a two-entry result queue. Depends on sfcs_pkg.
`default_nettype none
module sfcs_back (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 q_valid,
  input  wire sfcs_pkg::cls_item_t  q_item,
  output logic                      q_pop,
  output logic                      empty,
  input  wire logic                 pop,
  output sfcs_pkg::out_item_t       result
);
  import sfcs_pkg::*;

  // sequencer state
  logic [5:0]        step;
  logic [3:0]        cmd;
  logic [4:0]        phase;
  logic [2:0]        tx_bit;
  logic [1:0]        tx_sub;
  logic [8:0]        bidx;
  logic [31:0]       shin;
  logic [23:0]       addr;
  logic [FILL_W-1:0] fill;
  logic              cs_pin, clk_pin, mosi_pin, men_pin;

  logic [5:0]        step_next;
  logic [3:0]        cmd_next;
  logic [4:0]        phase_next;
  logic [2:0]        tx_bit_next;
  logic [1:0]        tx_sub_next;
  logic [8:0]        bidx_next;
  logic [31:0]       shin_next;
  logic [23:0]       addr_next;
  logic [FILL_W-1:0] fill_next;
  logic              cs_next, clkp_next, mosi_next, men_next;

  logic [7:0]  buf_mem [PAGE_BYTES];
  logic [7:0]  rd_data;
  logic [7:0]  rd_addr;
  logic        buf_we;

  out_item_t   res;
  out_item_t   oslot [2];
  logic        o_rd, o_wr;
  logic [1:0]  o_cnt;

  // temporaries of the tick
  elem_t       e;
  elem_t       e_after;
  logic [7:0]  tbyte;
  logic [4:0]  len;
  logic [4:0]  ph_inc;
  logic        run;

  assign q_pop = q_valid && (o_cnt != 2'd2);

  always_comb begin
    step_next   = step;
    cmd_next    = cmd;
    phase_next  = phase;
    tx_bit_next = tx_bit;
    tx_sub_next = tx_sub;
    bidx_next   = bidx;
    shin_next   = shin;
    addr_next   = addr;
    fill_next   = fill;
    cs_next     = cs_pin;
    clkp_next   = clk_pin;
    mosi_next   = mosi_pin;
    men_next    = men_pin;
    buf_we      = 1'b0;
    run         = 1'b0;
    res         = '0;
    e           = mk(K_FIN, 8'h00);
    e_after     = mk(K_FIN, 8'h00);
    tbyte       = 8'h00;
    len         = 5'd1;
    ph_inc      = 5'd0;

    if (step == SEQ_IDLE) begin
      if (q_item.is_load) begin
        if (fill < FILL_W'(PAGE_BYTES)) begin
          buf_we    = 1'b1;
          fill_next = fill + FILL_W'(1);
        end else begin
          res.rejected = 1'b1;
        end
      end else if (q_item.is_cmd) begin
        run         = 1'b1;
        cmd_next    = q_item.item.opcode;
        step_next   = 6'd0;
        phase_next  = 5'd0;
        tx_bit_next = 3'd0;
        tx_sub_next = 2'd0;
        bidx_next   = 9'd0;
        shin_next   = 32'd0;
        addr_next   = q_item.item.flash_address;
      end
    end else begin
      run          = 1'b1;
      res.rejected = (q_item.item.opcode >= OP_LOAD) && (q_item.item.opcode <= OP_WAKE);
    end

    if (run) begin
      res.busy_res = 1'b1;
      e = prog_elem(cmd_next, step_next);
      case (e.kind)
        K_A2:    tbyte = addr_next[23:16];
        K_A1:    tbyte = addr_next[15:8];
        K_A0:    tbyte = addr_next[7:0];
        K_DATA:  tbyte = rd_data;
        K_FF8:   tbyte = 8'hFF;
        default: tbyte = e.val;
      endcase

      case (e.kind)
        K_BEGIN: begin
          {cs_next, clkp_next, mosi_next, men_next} = 4'b0000;
        end
        K_END, K_FIN: begin
          {cs_next, clkp_next, mosi_next, men_next} = 4'b1000;
        end
        K_RX, K_RXD: begin
          len = RX_LEN;
          {cs_next, clkp_next, mosi_next, men_next} = {1'b0, phase_next[0], 1'b0, 1'b1};
          if (phase_next[0] && e.kind == K_RX) begin
            shin_next = {shin_next[30:0], q_item.item.miso_bit};
          end
        end
        default: begin
          len = TX_LEN;
          {cs_next, clkp_next, mosi_next, men_next} =
              {1'b0, (tx_sub_next == 2'd1), tbyte[~tx_bit_next], 1'b0};
        end
      endcase

      ph_inc = phase_next + 5'd1;
      if (tx_sub_next == 2'd2) begin
        tx_sub_next = 2'd0;
        tx_bit_next = tx_bit_next + 3'd1;
      end else begin
        tx_sub_next = tx_sub_next + 2'd1;
      end
      phase_next = ph_inc;

      if (ph_inc >= len) begin
        phase_next  = 5'd0;
        tx_sub_next = 2'd0;
        tx_bit_next = 3'd0;
        if (e.kind == K_FF8 && bidx_next < 9'd7) begin
          bidx_next = bidx_next + 9'd1;
        end else if (e.kind == K_DATA && ({1'b0, bidx_next} + 10'd1) < 10'(fill)) begin
          bidx_next = bidx_next + 9'd1;
        end else begin
          bidx_next = 9'd0;
          step_next = step_next + 6'd1;
          // program with an empty buffer skips its data element
          if (prog_elem(cmd_next, step_next).kind == K_DATA && fill == '0) begin
            step_next = step_next + 6'd1;
          end
        end
      end

      e_after = prog_elem(cmd_next, step_next);
      if (e.kind == K_FIN || e_after.kind == K_FIN) begin
        if (cmd_next == OP_STATUS || cmd_next == OP_ID) begin
          res.read_done  = 1'b1;
          res.read_value = shin_next;
        end
        if (cmd_next == OP_PROGRAM) fill_next = '0;
        step_next   = SEQ_IDLE;
        phase_next  = 5'd0;
        tx_sub_next = 2'd0;
        tx_bit_next = 3'd0;
        bidx_next   = 9'd0;
      end
    end

    res.cs_n        = cs_next;
    res.sclk        = clkp_next;
    res.mosi        = mosi_next;
    res.miso_enable = men_next;
  end

  // read data always reflects the byte index the next tick will use
  assign rd_addr = q_pop ? bidx_next[BUF_AW-1:0] : bidx[BUF_AW-1:0];

  always_ff @(posedge clk) begin
    if (q_pop && buf_we) begin
      buf_mem[fill[BUF_AW-1:0]] <= q_item.item.data_byte;
    end
    rd_data <= buf_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step     <= SEQ_IDLE;
      cmd      <= OP_TICK;
      phase    <= 5'd0;
      tx_bit   <= 3'd0;
      tx_sub   <= 2'd0;
      bidx     <= 9'd0;
      shin     <= 32'd0;
      addr     <= 24'd0;
      fill     <= '0;
      cs_pin   <= 1'b1;
      clk_pin  <= 1'b0;
      mosi_pin <= 1'b0;
      men_pin  <= 1'b0;
    end else if (q_pop) begin
      step     <= step_next;
      cmd      <= cmd_next;
      phase    <= phase_next;
      tx_bit   <= tx_bit_next;
      tx_sub   <= tx_sub_next;
      bidx     <= bidx_next;
      shin     <= shin_next;
      addr     <= addr_next;
      fill     <= fill_next;
      cs_pin   <= cs_next;
      clk_pin  <= clkp_next;
      mosi_pin <= mosi_next;
      men_pin  <= men_next;
    end
  end

  // result queue
  assign empty  = (o_cnt == 2'd0);
  assign result = oslot[o_rd];

  always_ff @(posedge clk) begin
    if (q_pop) begin
      oslot[o_wr] <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      o_rd  <= 1'b0;
      o_wr  <= 1'b0;
      o_cnt <= 2'd0;
    end else begin
      if (q_pop) o_wr <= !o_wr;
      if (pop && !empty) o_rd <= !o_rd;
      o_cnt <= o_cnt + 2'(q_pop) - 2'(pop && !empty);
    end
  end

  a_cmd_valid: assert property (@(posedge clk) disable iff (rst)
    (step != SEQ_IDLE) |-> (cmd >= OP_STATUS && cmd <= OP_WAKE))
    else $error("running sequence with bad command");
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= FILL_W'(PAGE_BYTES))
    else $error("page fill beyond buffer");
  a_step_range: assert property (@(posedge clk) disable iff (rst)
    (step == SEQ_IDLE) || (step < SEQ_LEN))
    else $error("sequence step out of range");
  a_oq_bound: assert property (@(posedge clk) disable iff (rst)
    o_cnt <= 2'd2)
    else $error("result queue overflow");

endmodule
`default_nettype wire

// File: hdl/spi_flash_command_sequencer.sv
// Top level of the SPI NOR flash command sequencer: front queue plus back-end
// sequencer. Each beat in gives one result beat with one pin write.
// Each input beat is registered in the front queue and its result in the result queue.
// Throughput: one beat per cycle while the result queue is not full; a full result queue stalls the sequencer.
// Reset (rst, synchronous): queues empty, sequencer idle, cs high, page fill 0;
// page buffer contents undefined until loaded.
`default_nettype none
module spi_flash_command_sequencer (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 push,
  output logic                      full,
  input  wire sfcs_pkg::in_item_t   item,
  output logic                      empty,
  input  wire logic                 pop,
  output sfcs_pkg::out_item_t       result
);
  import sfcs_pkg::*;

  logic      q_valid;
  logic      q_pop;
  cls_item_t q_item;

  sfcs_front u_front (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .full    (full),
    .item    (item),
    .q_valid (q_valid),
    .q_item  (q_item),
    .q_pop   (q_pop)
  );

  sfcs_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_valid),
    .q_item  (q_item),
    .q_pop   (q_pop),
    .empty   (empty),
    .pop     (pop),
    .result  (result)
  );

endmodule
`default_nettype wire

// File: bench/testbench.sv
// Self-checking bench for spi_flash_command_sequencer: drives ticks, loads and commands
// through the input queue and checks every pin-write beat against a local predictor.
// Depends on hdl/sfcs_pkg.sv and the RTL top level.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import sfcs_pkg::*;

  localparam logic [5:0] STEP_IDLE = 6'd63;
  localparam logic [3:0] OP_UNUSED = 4'd15;

  logic clk, rst, push, pop;
  logic full, empty;
  in_item_t item;
  out_item_t result;

  spi_flash_command_sequencer uut (
    .clk(clk), .rst(rst), .push(push), .full(full), .item(item),
    .empty(empty), .pop(pop), .result(result)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // predictor state
  logic [5:0]  seq_step;
  logic [3:0]  cur_cmd;
  int unsigned phase;
  int unsigned byte_idx;
  logic [31:0] rx_shift;
  logic [23:0] addr_latch;
  logic [7:0]  page_mem [256];
  int unsigned page_count;
  logic [3:0]  pins; // {miso_en, cs, clk, mosi}

  out_item_t pin_queue[$];
  int errors;
  int long_hold;

  function automatic void pins_reset();
    seq_step = STEP_IDLE; cur_cmd = OP_TICK; phase = 0; byte_idx = 0;
    rx_shift = 0; addr_latch = 0; page_count = 0; pins = 4'b0100;
  endfunction

  function automatic logic [15:0] wr_step(int s, logic [7:0] opc, bit data);
    case (s)
      0: return {8'(K_BEGIN), 8'h00};
      1: return {8'(K_TX), 8'h06};
      2: return {8'(K_END), 8'h00};
      3: return {8'(K_BEGIN), 8'h00};
      4: return {8'(K_TX), opc};
      5: return {8'(K_A2), 8'h00};
      6: return {8'(K_A1), 8'h00};
      7: return {8'(K_A0), 8'h00};
      8: return data ? {8'(K_DATA), 8'h00} : {8'(K_END), 8'h00};
      9: return data ? {8'(K_END), 8'h00} : {8'(K_FIN), 8'h00};
      default: return {8'(K_FIN), 8'h00};
    endcase
  endfunction

  // {kind, byte} of the current microcode step
  function automatic logic [15:0] step_code();
    int s;
    s = seq_step;
    if (s >= 16) return {8'(K_FIN), 8'h00};
    case (cur_cmd)
      OP_STATUS: case (s)
        0: return {8'(K_BEGIN), 8'h00};
        1: return {8'(K_TX), 8'h05};
        2: return {8'(K_RX), 8'h00};
        3: return {8'(K_END), 8'h00};
        default: return {8'(K_FIN), 8'h00};
      endcase
      OP_ID: case (s)
        0, 8: return {8'(K_BEGIN), 8'h00};
        1: return {8'(K_TX), 8'h90};
        2, 3, 4: return {8'(K_TX), 8'h00};
        5, 6, 11, 12: return {8'(K_RX), 8'h00};
        7, 13: return {8'(K_END), 8'h00};
        9: return {8'(K_TX), 8'h9F};
        10: return {8'(K_RXD), 8'h00};
        default: return {8'(K_FIN), 8'h00};
      endcase
      OP_ERASE4K: return wr_step(s, 8'h20, 0);
      OP_ERASE32K: return wr_step(s, 8'h52, 0);
      OP_ERASE64K: return wr_step(s, 8'hD8, 0);
      OP_PROGRAM: return wr_step(s, 8'h02, 1);
      OP_RESET: case (s)
        0, 3: return {8'(K_BEGIN), 8'h00};
        1: return {8'(K_FF8), 8'h00};
        2, 5: return {8'(K_END), 8'h00};
        4: return {8'(K_TX), 8'hAB};
        default: return {8'(K_FIN), 8'h00};
      endcase
      OP_SLEEP, OP_WAKE: case (s)
        0: return {8'(K_BEGIN), 8'h00};
        1: return {8'(K_TX), (cur_cmd == OP_SLEEP) ? 8'hB9 : 8'hAB};
        2: return {8'(K_END), 8'h00};
        default: return {8'(K_FIN), 8'h00};
      endcase
      default: return {8'(K_FIN), 8'h00};
    endcase
  endfunction

  function automatic void bit_bang(logic miso, ref out_item_t r);
    logic [15:0] code;
    logic [7:0] kind, data;
    int unsigned len;
    logic b;
    code = step_code();
    kind = code[15:8];
    data = code[7:0];
    len = 1;
    if (kind == K_A2) data = addr_latch[23:16];
    else if (kind == K_A1) data = addr_latch[15:8];
    else if (kind == K_A0) data = addr_latch[7:0];
    else if (kind == K_DATA) data = page_mem[byte_idx[7:0]];
    else if (kind == K_FF8) data = 8'hFF;
    if (kind == K_BEGIN) pins = 4'b0000;
    else if (kind == K_END || kind == K_FIN) pins = 4'b0100;
    else if (kind == K_RX || kind == K_RXD) begin
      len = 17;
      pins = {1'b1, 1'b0, phase[0], 1'b0};
      if (phase[0] && kind == K_RX) rx_shift = {rx_shift[30:0], miso};
    end else begin
      len = 24;
      b = data[7 - (phase / 3)];
      pins = {2'b00, (phase % 3) == 1, b};
    end
    phase++;
    if (phase >= len) begin
      phase = 0;
      if (kind == K_FF8 && byte_idx < 7) byte_idx++;
      else if (kind == K_DATA && byte_idx + 1 < page_count) byte_idx++;
      else begin
        byte_idx = 0;
        seq_step++;
        // empty program skips the data step
        while (seq_step < 16 && step_code() >> 8 == K_DATA && page_count == 0) seq_step++;
      end
    end
    if (kind == K_FIN || step_code() >> 8 == K_FIN) begin
      if (cur_cmd == OP_STATUS || cur_cmd == OP_ID) begin
        r.read_done = 1'b1;
        r.read_value = rx_shift;
      end
      if (cur_cmd == OP_PROGRAM) page_count = 0;
      seq_step = STEP_IDLE; phase = 0; byte_idx = 0;
    end
  endfunction

  function automatic out_item_t predict_pins(in_item_t it);
    out_item_t r;
    r = '0;
    if (seq_step == STEP_IDLE) begin
      if (it.opcode == OP_LOAD) begin
        if (page_count < PAGE_BYTES) begin
          page_mem[page_count[7:0]] = it.data_byte;
          page_count++;
        end else r.rejected = 1'b1;
      end else if (it.opcode >= OP_STATUS && it.opcode <= OP_WAKE) begin
        cur_cmd = it.opcode; seq_step = 0; phase = 0; byte_idx = 0;
        rx_shift = 0; addr_latch = it.flash_address;
        r.busy_res = 1'b1;
        bit_bang(it.miso_bit, r);
      end
    end else begin
      if (it.opcode >= OP_LOAD && it.opcode <= OP_WAKE) r.rejected = 1'b1;
      r.busy_res = 1'b1;
      bit_bang(it.miso_bit, r);
    end
    r.cs_n = pins[2]; r.sclk = pins[1]; r.mosi = pins[0]; r.miso_enable = pins[3];
    return r;
  endfunction

  // push stays high between back-to-back beats; it drops only for an idle gap
  task automatic send_beat(logic [3:0] op, logic [23:0] adr, logic [7:0] db, logic mb);
    int gap;
    gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push <= 1'b1;
    item <= '{opcode: op, flash_address: adr, data_byte: db, miso_bit: mb};
    @(posedge clk);
    while (full) @(posedge clk);
    pin_queue.push_back(predict_pins(item));
  endtask

  task automatic send_random(logic [3:0] op);
    send_beat(op, 24'($urandom), 8'($urandom), 1'($urandom_range(0, 1)));
  endtask

  task automatic run_ticks(int n);
    repeat (n) send_random(OP_TICK);
  endtask

  // random opcodes while a sequence runs: loads and commands are refused
  task automatic run_busy();
    while (seq_step != STEP_IDLE) send_random(4'($urandom_range(0, 15)));
  endtask

  // result side
  always @(posedge clk) begin
    if (!rst && pop && !empty) begin
      if (pin_queue.size() == 0) begin
        $display("%0t: unexpected beat %h", $time, result);
        errors++;
      end else begin
        out_item_t e;
        e = pin_queue.pop_front();
        if (e !== result) begin
          $display("%0t: mismatch expected %h actual %h", $time, e, result);
          errors++;
        end
      end
    end
  end

  initial begin
    int w;
    pop = 1'b0;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (long_hold > 0) begin
        pop <= 1'b0;
        repeat (long_hold) @(posedge clk);
        long_hold = 0;
      end
      w = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(0, 11);
      if (w > 0) begin
        pop <= 1'b0;
        repeat (w) @(posedge clk);
      end
      pop <= 1'b1;
    end
  end

  task automatic test_directed();
    logic [3:0] op;
    send_random(OP_TICK);
    send_beat(OP_UNUSED, 24'hFFFFFF, 8'hFF, 1'b1);
    send_beat(OP_LOAD, 24'h0, 8'hA5, 1'b1);
    for (op = OP_STATUS; op <= OP_WAKE; op++) begin
      send_beat(op, op[0] ? 24'hFFFFFF : 24'h000000, 8'h5A, 1'b1);
      run_busy();
    end
    send_beat(OP_PROGRAM, 24'h123456, 8'h0, 1'b0); // empty program
    run_busy();
  endtask

  task automatic test_backpressure();
    long_hold = 200;
    run_ticks(30);
  endtask

  task automatic test_random();
    logic [3:0] op;
    repeat (12) begin
      op = 4'($urandom_range(0, 15));
      if (op >= OP_STATUS && op <= OP_WAKE) op = OP_LOAD;
      send_random(op);
    end
  endtask

  task automatic test_full_page();
    while (page_count < PAGE_BYTES) send_random(OP_LOAD);
    send_random(OP_LOAD);     // overflow
    send_random(OP_PROGRAM);
    run_ticks(40);
  endtask

  initial begin
    errors = 0; long_hold = 0;
    pins_reset();
    rst = 1'b1; push = 1'b0; item = '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_backpressure();
    test_random();
    test_full_page();
    push <= 1'b0;
    while (pin_queue.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (errors == 0) $display("spi_flash_command_sequencer verification clean");
    else $display("spi_flash_command_sequencer verification failed");
    $finish;
  end

  initial begin
    #4000000;
    $display("spi_flash_command_sequencer verification failed");
    $finish;
  end
endmodule

// File: filelist.f
hdl/sfcs_pkg.sv
hdl/sfcs_front.sv
hdl/sfcs_back.sv
hdl/spi_flash_command_sequencer.sv
bench/testbench.sv
